// ===== design/rlid_pkg.sv =====
// rlid_pkg: shared constants and types for the run-length image decoder
// no dependencies; used by rlid_step and run_length_image_decoder
package rlid_pkg;

    // field widths
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned COLOR_W = 6;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned IDX_W   = 1;
    localparam int unsigned OUT_W   = 40;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

    // register reset values
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 10'd320;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 10'd240;

    // control codes of a byte with top bits clear
    localparam logic [CODE_W-1:0] CODE_FRAME_SEP = 8'd33;
    localparam logic [CODE_W-1:0] CODE_FILL_ROW  = 8'd35;
    localparam logic [CODE_W-1:0] CODE_LONG_LEN  = 8'd36;

    localparam logic [POS_W-1:0] ROW_MAX = 10'd1023;

    // decoder state
    typedef struct packed {
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        logic [COLOR_W-1:0] last_color;
        logic               awaiting_length;
        logic               frame_done;
    } t_state;

    // one decoded run
    typedef struct packed {
        logic               frame_end;
        logic [POS_W-1:0]   length;
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
    } t_run;

endpackage

// ===== design/rlid_step.sv =====
// rlid_step: decode of one code byte against the current decoder state
// depends on rlid_pkg (state and run types, control codes)
module rlid_step (
    input  logic [rlid_pkg::CODE_W-1:0] i_code,
    input  logic                        i_frame_start,
    input  logic [rlid_pkg::CFG_W-1:0]  i_line_width,
    input  logic [rlid_pkg::CFG_W-1:0]  i_frame_rows,
    input  rlid_pkg::t_state            i_state,
    output rlid_pkg::t_state            o_state,
    output logic                        o_emit,
    output rlid_pkg::t_run              o_run
);
    import rlid_pkg::*;

    t_state           s0;
    logic [POS_W-1:0] width;
    logic             do_run;
    logic             fill;
    logic             fend;
    logic [POS_W-1:0] req_len;
    logic [POS_W-1:0] c1;
    logic [POS_W-1:0] r1;
    logic [POS_W-1:0] room;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] c2;
    logic             take;

    // frame start clears position and flags, colour is kept
    always_comb begin
        s0 = i_state;
        if (i_frame_start) begin
            s0.column          = '0;
            s0.row             = '0;
            s0.awaiting_length = 1'b0;
            s0.frame_done      = 1'b0;
        end
    end

    // zero width acts as one
    assign width = (i_line_width == '0) ? POS_W'(1) : i_line_width;

    // byte classification and state flags
    always_comb begin
        o_state = s0;
        do_run  = 1'b0;
        fill    = 1'b0;
        fend    = 1'b0;
        req_len = '0;
        if (!s0.frame_done) begin
            if (s0.awaiting_length) begin
                o_state.awaiting_length = 1'b0;
                do_run  = 1'b1;
                req_len = POS_W'(i_code);
            end else if (i_code[CODE_W-1 -: 2] != 2'b00) begin
                o_state.last_color = i_code[COLOR_W-1:0];
                do_run  = 1'b1;
                req_len = POS_W'(i_code[CODE_W-1 -: 2]);
            end else if (i_code == CODE_LONG_LEN) begin
                o_state.awaiting_length = 1'b1;
            end else if (i_code == CODE_FILL_ROW) begin
                do_run = (s0.column != '0);
                fill   = 1'b1;
            end else if (i_code == CODE_FRAME_SEP) begin
                o_state.frame_done = 1'b1;
                do_run = 1'b1;
                fill   = 1'b1;
                fend   = 1'b1;
            end else begin
                do_run  = 1'b1;
                req_len = POS_W'(i_code);
            end
        end
        // position update of a run
        if (do_run) begin
            o_state.column = c1;
            o_state.row    = r1;
            if (take) begin
                if (c2 >= width) begin
                    o_state.column = '0;
                    o_state.row    = (r1 == ROW_MAX) ? r1 : r1 + POS_W'(1);
                end else begin
                    o_state.column = c2;
                end
            end
        end
    end

    // wrap a column left beyond the width, then cut at row end
    always_comb begin
        if (s0.column >= width) begin
            c1 = '0;
            r1 = (s0.row == ROW_MAX) ? s0.row : s0.row + POS_W'(1);
        end else begin
            c1 = s0.column;
            r1 = s0.row;
        end
        room = width - c1;
        len  = (fill || req_len > room) ? room : req_len;
        c2   = c1 + len;
        take = (len != '0) && (r1 < i_frame_rows);
    end

    assign o_emit        = do_run && take;
    assign o_run.row       = r1;
    assign o_run.col       = c1;
    assign o_run.color     = o_state.last_color;
    assign o_run.length    = len;
    assign o_run.frame_end = fend;

endmodule

// ===== design/run_length_image_decoder.sv =====
// run_length_image_decoder: top level, input register, state, result register
// depends on rlid_pkg and rlid_step
//
//  channel   dir  signals                       contents
//  s_axis    in   tvalid tready tdata tuser     code byte, frame start flag
//  m_axis    out  tvalid tready tdata tlast     run row/col/color/length, frame end
//  cfg       in   i_cfg_we i_cfg_index data     line width (0), frame rows (1)
//
// one byte per cycle sustained while the result is not stalled; path: input register, then result register
// the decode of the byte held in the input register updates the state when that byte moves on
// reset (synchronous, active low) empties both registers and restores the defaults
// a stalled result holds the input register; the input takes a byte whenever
// the input register is empty or moves on in the same cycle
module run_length_image_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rlid_pkg::CODE_W-1:0]   s_axis_tdata,  // [7:0] code_byte
    input  logic                          s_axis_tuser,  // [0] frame_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [9:0] run_row, [19:10] run_col, [25:20] run_color, [35:26] run_length, zeros
    output logic [rlid_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,  // frame_end
    input  logic                          i_cfg_we,
    input  logic [rlid_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [rlid_pkg::CFG_W-1:0]    i_cfg_data
);
    import rlid_pkg::*;

    logic              r_in_valid;
    logic [CODE_W-1:0] r_in_code;
    logic              r_in_fs;
    logic [CFG_W-1:0]  r_line_width;
    logic [CFG_W-1:0]  r_frame_rows;
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    t_run              r_out;
    t_run              n_run;
    logic              n_emit;
    logic              adv;

    // the held byte moves on when the result register is free or emptying
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_frame_rows <= FRAME_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_code <= s_axis_tdata;
            r_in_fs   <= s_axis_tuser;
        end
    end

    // byte decode
    rlid_step u_step (
        .i_code        (r_in_code),
        .i_frame_start (r_in_fs),
        .i_line_width  (r_line_width),
        .i_frame_rows  (r_frame_rows),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_emit        (n_emit),
        .o_run         (n_run)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && n_emit) begin
            r_out <= n_run;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.length, r_out.color, r_out.col, r_out.row};
    assign m_axis_tlast  = r_out.frame_end;

endmodule
